// ===== design/suhc_pkg.sv =====
// shared types, codes and crc helper for the serial upload handshake block
`timescale 1ns / 1ps

package suhc_pkg;

    // input operation codes
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // finish status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_RESET_REF   = 3'd1;
    localparam logic [2:0] ST_START_REF   = 3'd2;
    localparam logic [2:0] ST_SIZE_REF    = 3'd3;
    localparam logic [2:0] ST_DATA_REF    = 3'd4;
    localparam logic [2:0] ST_CRC_ERR     = 3'd5;
    localparam logic [2:0] ST_CRC_UNKNOWN = 3'd6;
    localparam logic [2:0] ST_TIMEOUT     = 3'd7;

    // result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // link bytes
    localparam logic [7:0] TX_RESET = 8'h00;
    localparam logic [7:0] TX_START = 8'h01;
    localparam logic [7:0] RX_R     = 8'h52;
    localparam logic [7:0] RX_S     = 8'h53;
    localparam logic [7:0] RX_D     = 8'h44;
    localparam logic [7:0] RX_C     = 8'h43;
    localparam logic [7:0] RX_O     = 8'h4F;
    localparam logic [7:0] RX_E     = 8'h45;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
    localparam logic [31:0] SIZE_EXTRA  = 32'd4;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WRESET,
        PH_WSTART,
        PH_WSIZE,
        PH_DATA,
        PH_WDATA,
        PH_WCRC
    } phase_t;

    // all results caused by one word, handed from control to the output stage
    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [1:0]  last_idx;
        logic [31:0] tx_word;
        logic [2:0]  status;
        logic [31:0] crc_value;
    } bundle_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/suhc_ctrl.sv =====
// handshake phase machine, crc and counters; builds the result bundle per word
`timescale 1ns / 1ps

module suhc_ctrl
    import suhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_fire,
    input  logic [1:0]  op,
    input  logic [7:0]  value,
    input  logic [31:0] length,
    output bundle_t     bundle
);

    phase_t      phase_reg, phase_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] left_reg, left_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] timeout_reg;
    logic [15:0] wait_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            crc_reg     <= CRC_INIT;
            left_reg    <= '0;
            wait_reg    <= '0;
            timeout_reg <= TIMEOUT_RST;
        end else begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            left_reg  <= left_next;
            wait_reg  <= wait_next;
            if (cfg_wr_en) begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    assign wait_inc = (wait_reg == WAIT_MAX) ? wait_reg : wait_reg + 16'd1;

    always_comb begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        left_next  = left_reg;
        wait_next  = wait_reg;
        bundle     = '0;

        if (in_fire) begin
            unique case (op)
                OP_BEGIN: begin
                    crc_next            = CRC_INIT;
                    left_next           = length;
                    bundle.valid        = 1'b1;
                    bundle.tx_word[7:0] = TX_RESET;
                    phase_next          = PH_WRESET;
                    wait_next           = '0;
                end
                OP_DATA: begin
                    if (phase_reg == PH_DATA) begin
                        crc_next            = crc_byte(crc_reg, value);
                        left_next           = left_reg - 32'd1;
                        bundle.valid        = 1'b1;
                        bundle.tx_word[7:0] = value;
                        if (left_reg == 32'd1) begin
                            phase_next = PH_WDATA;
                            wait_next  = '0;
                        end
                    end
                end
                OP_REPLY: begin
                    // any refusal ends the upload with a single status result
                    bundle.crc_value = ~crc_reg;
                    unique case (phase_reg)
                        PH_WRESET: begin
                            bundle.valid = 1'b1;
                            if (value == RX_R) begin
                                bundle.tx_word[7:0] = TX_START;
                                phase_next          = PH_WSTART;
                                wait_next           = '0;
                            end else begin
                                bundle.kind   = KIND_DONE;
                                bundle.status = ST_RESET_REF;
                                phase_next    = PH_IDLE;
                            end
                        end
                        PH_WSTART: begin
                            bundle.valid = 1'b1;
                            if (value == RX_S) begin
                                bundle.tx_word  = left_reg + SIZE_EXTRA;
                                bundle.last_idx = 2'd3;
                                phase_next      = PH_WSIZE;
                                wait_next       = '0;
                            end else begin
                                bundle.kind   = KIND_DONE;
                                bundle.status = ST_START_REF;
                                phase_next    = PH_IDLE;
                            end
                        end
                        PH_WSIZE: begin
                            if (value == RX_D) begin
                                wait_next = '0;
                                // empty payload skips the data phase
                                phase_next = (left_reg == '0) ? PH_WDATA : PH_DATA;
                            end else begin
                                bundle.valid  = 1'b1;
                                bundle.kind   = KIND_DONE;
                                bundle.status = ST_SIZE_REF;
                                phase_next    = PH_IDLE;
                            end
                        end
                        PH_WDATA: begin
                            bundle.valid = 1'b1;
                            if (value == RX_C) begin
                                bundle.tx_word  = ~crc_reg;
                                bundle.last_idx = 2'd3;
                                phase_next      = PH_WCRC;
                                wait_next       = '0;
                            end else begin
                                bundle.kind   = KIND_DONE;
                                bundle.status = ST_DATA_REF;
                                phase_next    = PH_IDLE;
                            end
                        end
                        PH_WCRC: begin
                            bundle.valid = 1'b1;
                            bundle.kind  = KIND_DONE;
                            phase_next   = PH_IDLE;
                            if (value == RX_O) begin
                                bundle.status = ST_OK;
                            end else if (value == RX_E) begin
                                bundle.status = ST_CRC_ERR;
                            end else begin
                                bundle.status = ST_CRC_UNKNOWN;
                            end
                        end
                        default: begin
                            bundle.crc_value = '0;
                        end
                    endcase
                end
                OP_TICK: begin
                    if (phase_reg != PH_IDLE && phase_reg != PH_DATA) begin
                        wait_next = wait_inc;
                        if (wait_inc >= timeout_reg) begin
                            bundle.valid     = 1'b1;
                            bundle.kind      = KIND_DONE;
                            bundle.status    = ST_TIMEOUT;
                            bundle.crc_value = ~crc_reg;
                            phase_next       = PH_IDLE;
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

endmodule

// ===== design/suhc_out.sv =====
// result register that hands out the bundled results one word at a time
`timescale 1ns / 1ps

module suhc_out
    import suhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  bundle_t     bundle,
    output logic        free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_tx_byte,
    output logic        m_last,
    output logic [2:0]  m_status,
    output logic [31:0] m_crc_value
);

    bundle_t    bun_reg;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       at_last;

    assign at_last = (idx_reg == bun_reg.last_idx);
    // room for a new bundle when empty or the final word leaves this cycle
    assign free    = !valid_reg || (m_ready && at_last);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (valid_reg && m_ready) begin
            if (at_last) begin
                valid_next = 1'b0;
                idx_next   = '0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load) begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bun_reg <= bundle;
        end
    end

    assign m_valid     = valid_reg;
    assign m_kind      = bun_reg.kind;
    assign m_tx_byte   = (bun_reg.kind == KIND_DONE) ? 8'd0 : bun_reg.tx_word[8*idx_reg +: 8];
    assign m_last      = at_last;
    assign m_status    = (bun_reg.kind == KIND_DONE) ? bun_reg.status : 3'd0;
    assign m_crc_value = (bun_reg.kind == KIND_DONE) ? bun_reg.crc_value : 32'd0;

endmodule

// ===== design/serial_upload_handshake_crc.sv =====
// top level of the serial upload handshake sender with crc-32
//
// channel   dir  handshake            payload
// s_        in   s_valid / s_ready    s_op, s_value, s_length
// m_        out  m_valid / m_ready    m_kind, m_tx_byte, m_last, m_status, m_crc_value
// cfg_      in   cfg_wr_en            cfg_wr_data (timeout in ticks)
//
// a word is processed in the cycle it is accepted; its results (zero to four
// words) appear from the next cycle out of the result register, one per cycle.
// words with one or no result can be taken every cycle; a size or crc send
// holds s_ready low until its four bytes have drained.
// reset is synchronous active low and leaves the block idle with timeout 1000.
// m_ready low stalls the result register and, once it is full, the input.
`timescale 1ns / 1ps

module serial_upload_handshake_crc
    import suhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_value,
    input  logic [31:0] s_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_tx_byte,
    output logic        m_last,
    output logic [2:0]  m_status,
    output logic [31:0] m_crc_value
);

    bundle_t bundle;
    logic    in_fire;
    logic    out_free;

    assign s_ready = out_free;
    assign in_fire = s_valid && out_free;

    suhc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .op          (s_op),
        .value       (s_value),
        .length      (s_length),
        .bundle      (bundle)
    );

    suhc_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (in_fire && bundle.valid),
        .bundle      (bundle),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_tx_byte   (m_tx_byte),
        .m_last      (m_last),
        .m_status    (m_status),
        .m_crc_value (m_crc_value)
    );

endmodule
